FILE: sv/sqt_pkg.sv
// ----------------------------------------------------------------------------
// sqt_pkg
// shared types, token kind codes and keyword tables for the query tokenizer
// ----------------------------------------------------------------------------
package sqt_pkg;

    localparam int KEYWORD_COUNT_DEF      = 18;
    localparam int MAX_KEYWORD_LENGTH_DEF = 7;
    localparam int MAX_RESULTS            = 3;
    localparam int QUEUE_DEPTH            = 4;

    localparam logic [3:0] KIND_END        = 4'd0;
    localparam logic [3:0] KIND_NUMBER     = 4'd1;
    localparam logic [3:0] KIND_KEYWORD    = 4'd2;
    localparam logic [3:0] KIND_IDENT      = 4'd3;
    localparam logic [3:0] KIND_STRING_END = 4'd4;
    localparam logic [3:0] KIND_DELIM      = 4'd5;
    localparam logic [3:0] KIND_WORD_CHAR  = 4'd6;
    localparam logic [3:0] KIND_STR_CHAR   = 4'd7;
    localparam logic [3:0] KIND_OVERFLOW   = 4'd8;

    localparam logic [7:0]  CHAR_QUOTE      = 8'h27;
    localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5f;
    localparam logic [31:0] OVF_MARK        = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } sqt_in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [30:0] token_value;
        logic        last_of_run;
    } sqt_out_t;

    typedef struct packed {
        logic [1:0]                       count;
        sqt_out_t [MAX_RESULTS-1:0]       res;
    } bundle_t;

    function automatic sqt_out_t make_res(input logic [3:0] kind, input logic [30:0] val);
        sqt_out_t r;
        r.token_kind  = kind;
        r.token_value = val;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[8'h61:8'h7a], [8'h41:8'h5a]});
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b inside {8'd32, [8'd9:8'd13]});
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b inside {[8'h41:8'h5a]}) ? b + 8'd32 : b;
    endfunction

    // keyword text, right aligned
    function automatic logic [55:0] kw_word(input logic [4:0] k);
        case (k)
            5'd0:    return 56'("select");
            5'd1:    return 56'("from");
            5'd2:    return 56'("where");
            5'd3:    return 56'("and");
            5'd4:    return 56'("insert");
            5'd5:    return 56'("into");
            5'd6:    return 56'("values");
            5'd7:    return 56'("delete");
            5'd8:    return 56'("update");
            5'd9:    return 56'("set");
            5'd10:   return 56'("create");
            5'd11:   return 56'("table");
            5'd12:   return 56'("int");
            5'd13:   return 56'("varchar");
            5'd14:   return 56'("view");
            5'd15:   return 56'("as");
            5'd16:   return 56'("index");
            5'd17:   return 56'("on");
            default: return 56'd0;
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] k);
        case (k)
            5'd0, 5'd4, 5'd6, 5'd7, 5'd8, 5'd10: return 4'd6;
            5'd1, 5'd5, 5'd14:                   return 4'd4;
            5'd2, 5'd11, 5'd16:                  return 4'd5;
            5'd3, 5'd9, 5'd12:                   return 4'd3;
            5'd13:                               return 4'd7;
            5'd15, 5'd17:                        return 4'd2;
            default:                             return 4'd0;
        endcase
    endfunction

    // character p of keyword k, valid for p below its length
    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] p);
        logic [3:0]  d;
        logic [5:0]  sh;
        logic [55:0] t;
        d  = kw_len(k) - 4'd1 - p;
        sh = {d[2:0], 3'b000};
        t  = kw_word(k) >> sh;
        return t[7:0];
    endfunction

endpackage

FILE: sv/sqt_front.sv
// ----------------------------------------------------------------------------
// sqt_front
// lexer front: byte classification, token state and per-byte result bundle
// ----------------------------------------------------------------------------
module sqt_front
    import sqt_pkg::*;
#(
    parameter int KEYWORD_COUNT      = KEYWORD_COUNT_DEF,
    parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  sqt_in_t item,
    input  logic    accept,
    output bundle_t bundle,
    output logic    bundle_valid
);

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NUMBER = 4'b0010,
        MODE_WORD   = 4'b0100,
        MODE_STRING = 4'b1000
    } mode_t;

    localparam logic [KEYWORD_COUNT-1:0] ALL_CAND = '1;

    mode_t                    mode_reg, mode_next, mode_mid;
    logic [31:0]              acc_reg, acc_next, acc_mid;
    logic [KEYWORD_COUNT-1:0] cand_reg, cand_next, cand_mid;
    logic [3:0]               pos_reg, pos_next, pos_mid;

    logic [7:0] b, c;
    logic       fin, digit, wchar, quote, space;
    logic       cont_num, cont_word, in_string, do_start, num_step, word_step;
    logic [3:0] slot_v;
    sqt_out_t   slot [4];
    logic [1:0] n;

    function automatic logic [KEYWORD_COUNT-1:0] narrow(
        input logic [KEYWORD_COUNT-1:0] cand,
        input logic [3:0]               p,
        input logic [7:0]               ch
    );
        logic [KEYWORD_COUNT-1:0] r;
        r = cand;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (!(p < 4'(MAX_KEYWORD_LENGTH) && p < kw_len(5'(k)) && kw_char(5'(k), p) == ch))
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic sqt_out_t close_word(
        input logic [KEYWORD_COUNT-1:0] cand,
        input logic [3:0]               p
    );
        sqt_out_t r;
        logic     hit;
        r   = make_res(KIND_IDENT, 31'd0);
        hit = 1'b0;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (!hit && cand[k] && kw_len(5'(k)) == p && p <= 4'(MAX_KEYWORD_LENGTH))
            begin
                hit = 1'b1;
                r   = make_res(KIND_KEYWORD, 31'(k));
            end
        end
        return r;
    endfunction

    function automatic sqt_out_t close_number(input logic [31:0] acc);
        return acc[31] ? make_res(KIND_OVERFLOW, 31'd0) : make_res(KIND_NUMBER, acc[30:0]);
    endfunction

    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] ch);
        logic [34:0] base, v;
        base = {4'b0000, acc[30:0]};
        v    = (base << 3) + (base << 1) + 35'(ch[3:0]);
        if (acc[31])
        begin
            return acc;
        end
        return (v[34:31] != 4'd0) ? OVF_MARK : {1'b0, v[30:0]};
    endfunction

    always_comb
    begin
        b     = item.text_byte;
        fin   = item.end_of_text;
        c     = lower(b);
        digit = is_digit(b);
        wchar = is_alpha(b) || (b == CHAR_UNDERSCORE);
        quote = (b == CHAR_QUOTE);
        space = is_space(b);

        cont_num  = (mode_reg == MODE_NUMBER) && digit;
        cont_word = (mode_reg == MODE_WORD) && (wchar || digit);
        in_string = (mode_reg == MODE_STRING);
        do_start  = !cont_num && !cont_word && !in_string;
        num_step  = cont_num || (do_start && digit);
        word_step = cont_word || (do_start && wchar);

        slot_v = 4'b0000;
        for (int i = 0; i < 4; i++) begin
            slot[i] = make_res(KIND_END, 31'd0);
        end

        // token closed by this byte
        case (mode_reg)
            MODE_NUMBER:
            begin
                if (!digit)
                begin
                    slot_v[0] = 1'b1;
                    slot[0]   = close_number(acc_reg);
                end
            end
            MODE_WORD:
            begin
                if (!(wchar || digit))
                begin
                    slot_v[0] = 1'b1;
                    slot[0]   = close_word(cand_reg, pos_reg);
                end
            end
            default:
            begin
            end
        endcase

        if (in_string)
        begin
            mode_mid = quote ? MODE_IDLE : MODE_STRING;
        end
        else if (cont_num || (do_start && digit))
        begin
            mode_mid = MODE_NUMBER;
        end
        else if (word_step)
        begin
            mode_mid = MODE_WORD;
        end
        else if (quote)
        begin
            mode_mid = MODE_STRING;
        end
        else
        begin
            mode_mid = MODE_IDLE;
        end

        // result of this byte itself
        if (word_step)
        begin
            slot_v[1] = 1'b1;
            slot[1]   = make_res(KIND_WORD_CHAR, 31'(c));
        end
        else if (in_string)
        begin
            slot_v[1] = 1'b1;
            slot[1]   = quote ? make_res(KIND_STRING_END, 31'd0)
                              : make_res(KIND_STR_CHAR, 31'(b));
        end
        else if (do_start && !space && !digit && !quote)
        begin
            slot_v[1] = 1'b1;
            slot[1]   = make_res(KIND_DELIM, 31'(b));
        end

        acc_mid  = num_step ? add_digit(cont_num ? acc_reg : 32'd0, b) : acc_reg;
        cand_mid = word_step ? narrow(cont_word ? cand_reg : ALL_CAND,
                                      cont_word ? pos_reg : 4'd0, c) : cand_reg;
        if (word_step)
        begin
            pos_mid = cont_word ? ((pos_reg < 4'd15) ? pos_reg + 4'd1 : 4'd15) : 4'd1;
        end
        else
        begin
            pos_mid = pos_reg;
        end

        // flush at end of text
        if (fin)
        begin
            case (mode_mid)
                MODE_NUMBER:
                begin
                    slot_v[2] = 1'b1;
                    slot[2]   = close_number(acc_mid);
                end
                MODE_WORD:
                begin
                    slot_v[2] = 1'b1;
                    slot[2]   = close_word(cand_mid, pos_mid);
                end
                MODE_STRING:
                begin
                    slot_v[2] = 1'b1;
                    slot[2]   = make_res(KIND_STRING_END, 31'd0);
                end
                default:
                begin
                end
            endcase
            slot_v[3] = 1'b1;
        end

        // pack the first three results
        bundle = '0;
        n      = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (slot_v[i] && n != 2'd3)
            begin
                bundle.res[n] = slot[i];
                n             = n + 2'd1;
            end
        end
        if (n != 2'd0)
        begin
            bundle.res[n - 2'd1].last_of_run = 1'b1;
        end
        bundle.count = n;
        bundle_valid = (n != 2'd0);

        mode_next = fin ? MODE_IDLE : mode_mid;
        acc_next  = fin ? 32'd0 : acc_mid;
        cand_next = fin ? ALL_CAND : cand_mid;
        pos_next  = fin ? 4'd0 : pos_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 32'd0;
            cand_reg <= ALL_CAND;
            pos_reg  <= 4'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cand_reg <= cand_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

FILE: sv/sqt_queue.sv
// ----------------------------------------------------------------------------
// sqt_queue
// short queue of result bundles between lexer front and output stage
// ----------------------------------------------------------------------------
module sqt_queue
    import sqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output bundle_t rd_data,
    output logic    rd_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/sqt_back.sv
// ----------------------------------------------------------------------------
// sqt_back
// output stage: while the output register is free or popped, unpacks each bundle into single results, one per cycle
// ----------------------------------------------------------------------------
module sqt_back
    import sqt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bundle_t  bundle,
    input  logic     bundle_valid,
    output logic     bundle_pop,
    output sqt_out_t result,
    output logic     empty,
    input  logic     pop
);

    logic [1:0] idx_reg, idx_next;
    sqt_out_t   out_reg;
    logic       out_valid_reg, out_valid_next;
    logic       load;

    assign load       = bundle_valid && (!out_valid_reg || pop);
    assign bundle_pop = load && (idx_reg == bundle.count - 2'd1);
    assign result     = out_reg;
    assign empty      = !out_valid_reg;

    always_comb
    begin
        if (bundle_pop)
        begin
            idx_next = 2'd0;
        end
        else if (load)
        begin
            idx_next = idx_reg + 2'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end
        out_valid_next = load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= bundle.res[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/sql_query_tokenizer.sv
// ----------------------------------------------------------------------------
// sql_query_tokenizer
// streaming lexer for query text, one byte per request
// ----------------------------------------------------------------------------
// Accepts one text byte per clock while full is low. A byte that yields one
// result or none passes at one byte per cycle while pop keeps up; a byte that
// yields several results (at most three) holds the output for each in turn,
// since the output stage hands out one result per cycle while pop is high. A
// four-entry bundle queue between lexer front and output stage absorbs such
// bursts. A result is stored in the bundle queue, then in the output register.
// ----------------------------------------------------------------------------
module sql_query_tokenizer
    import sqt_pkg::*;
#(
    parameter int KEYWORD_COUNT      = KEYWORD_COUNT_DEF,
    parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  sqt_in_t  item,
    input  logic     push,
    output logic     full,
    output sqt_out_t result,
    output logic     empty,
    input  logic     pop
);

    logic    accept;
    bundle_t front_bundle, q_bundle;
    logic    front_valid, q_valid, q_pop;

    assign accept = push && !full;

    sqt_front #(
        .KEYWORD_COUNT      (KEYWORD_COUNT),
        .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .accept       (accept),
        .bundle       (front_bundle),
        .bundle_valid (front_valid)
    );

    sqt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && front_valid),
        .wr_data  (front_bundle),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (q_bundle),
        .rd_valid (q_valid)
    );

    sqt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle       (q_bundle),
        .bundle_valid (q_valid),
        .bundle_pop   (q_pop),
        .result       (result),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
